FILE: design/assert_macros.svh
// Assertion macros shared by the searchable queue RTL.
// Each macro has a live form for simulation and an empty form under SYNTH.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: state invariant");

// Antecedent implies consequent at the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/fqs_pkg.sv
// Shared types and constants for the searchable queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fqs_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int OCC_W    = 5;

    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic append;
        logic remove;
        logic compare;
        logic scan;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: design/fqs_cell.sv
// One queue cell: holds the entry at a fixed distance from the front and a match flag.
// Depends on fqs_pkg for the cell control struct.
`timescale 1ns / 1ps
`default_nettype none

module fqs_cell
    import fqs_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int CNT_W      = 5,
    parameter int INDEX      = 0
) (
    input  wire logic                  i_clk,
    input  wire t_cell_ctl             i_ctl,
    input  wire logic [CNT_W-1:0]      i_count,
    input  wire logic [DATA_WIDTH-1:0] i_word,
    input  wire logic [DATA_WIDTH-1:0] i_next_data,
    input  wire logic                  i_next_match,
    output logic      [DATA_WIDTH-1:0] o_data,
    output logic                       o_match
);

    localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  r_match;
    logic                  n_match;
    logic                  w_held;

    assign w_held = (MY_INDEX < i_count);

    always_comb begin
        n_data = r_data;
        if (i_ctl.append && (i_count == MY_INDEX)) begin
            n_data = i_word;
        end else if (i_ctl.remove) begin
            n_data = i_next_data;
        end
    end

    always_comb begin
        n_match = r_match;
        if (i_ctl.compare) begin
            n_match = w_held && (r_data == i_word);
        end else if (i_ctl.scan) begin
            n_match = i_next_match;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_match <= n_match;
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

`default_nettype wire

FILE: design/fifo_queue_with_search_core.sv
// Searchable FIFO queue: a row of cells, front entry in the first cell, with a control unit.
// Depends on fqs_pkg, fqs_cell and assert_macros.svh.
//
// Append, remove and clear complete from idle; busy stays low and the result strobes in the
// following cycle, so these can arrive every cycle. A search holds busy while it scans up to p,
// the position of the first match, or the occupancy when the value is absent: a compare state
// in which every cell compares its entry, then a scan state as the match flags shift
// toward the front and the control unit watches the first cell. Each result is on the ports
// for exactly one cycle with o_strobe high; there is no back-pressure, so capture it then.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fifo_queue_with_search_core
    import fqs_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic        [ACTION_W-1:0] i_action,
    input  wire logic signed [VALUE_W-1:0]  i_value,
    output logic                            o_strobe,
    output logic             [STATUS_W-1:0] o_status,
    output logic                            o_found,
    output logic             [POS_W-1:0]    o_position,
    output logic             [OCC_W-1:0]    o_occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [CNT_W-1:0]      r_pos;
    logic [CNT_W-1:0]      n_pos;
    logic [DATA_WIDTH-1:0] r_key;
    logic [DATA_WIDTH-1:0] n_key;
    logic                  r_strobe;
    logic                  n_strobe;
    logic [STATUS_W-1:0]   r_status;
    logic [STATUS_W-1:0]   n_status;
    logic                  r_found;
    logic                  n_found;
    logic [POS_W-1:0]      r_position;
    logic [POS_W-1:0]      n_position;
    logic [OCC_W-1:0]      r_occupancy;
    logic [OCC_W-1:0]      n_occupancy;

    logic                  w_accept;
    logic [63:0]           w_value_ext;
    logic [DATA_WIDTH-1:0] w_in_word;
    logic [DATA_WIDTH-1:0] w_word;
    t_cell_ctl             w_ctl;
    logic [CNT_W+POS_W-1:0] w_pos_ext;
    logic [CNT_W+OCC_W-1:0] w_occ_ext;

    logic [DATA_WIDTH-1:0] w_data  [DEPTH];
    logic                  w_match [DEPTH];

    assign w_accept    = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign w_value_ext = {{(64 - VALUE_W){i_value[VALUE_W-1]}}, i_value};
    assign w_in_word   = w_value_ext[DATA_WIDTH-1:0];
    assign w_word      = (r_state == S_CMP) ? r_key : w_in_word;
    assign w_pos_ext   = {{POS_W{1'b0}}, r_pos};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_key       = r_key;
        n_strobe    = 1'b0;
        n_status    = STAT_DONE;
        n_found     = 1'b0;
        n_position  = '0;
        w_ctl       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_action)
                        ACT_APPEND: begin
                            n_strobe = 1'b1;
                            if (r_count == FULL_COUNT) begin
                                n_status = STAT_FULL;
                            end else begin
                                w_ctl.append = 1'b1;
                                n_count      = r_count + 1'b1;
                            end
                        end
                        ACT_REMOVE: begin
                            n_strobe = 1'b1;
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                w_ctl.remove = 1'b1;
                                n_count      = r_count - 1'b1;
                            end
                        end
                        ACT_SEARCH: begin
                            n_key   = w_in_word;
                            n_state = S_CMP;
                        end
                        ACT_CLEAR: begin
                            n_strobe = 1'b1;
                            n_count  = '0;
                        end
                    endcase
                end
            end
            S_CMP: begin
                w_ctl.compare = 1'b1;
                n_pos         = '0;
                n_state       = S_SCAN;
            end
            S_SCAN: begin
                if (r_pos == r_count) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else if (w_match[0]) begin
                    n_strobe   = 1'b1;
                    n_found    = 1'b1;
                    n_position = w_pos_ext[POS_W-1:0];
                    n_state    = S_IDLE;
                end else begin
                    w_ctl.scan = 1'b1;
                    n_pos      = r_pos + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_occ_ext   = {{OCC_W{1'b0}}, n_count};
    assign n_occupancy = w_occ_ext[OCC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pos    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pos    <= n_pos;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_status    <= n_status;
        r_found     <= n_found;
        r_position  <= n_position;
        r_occupancy <= n_occupancy;
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_next_data;
        logic                  w_next_match;
        if (i == DEPTH - 1) begin : g_tail
            assign w_next_data  = '0;
            assign w_next_match = 1'b0;
        end else begin : g_link
            assign w_next_data  = w_data[i+1];
            assign w_next_match = w_match[i+1];
        end
        fqs_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .INDEX      (i)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_count      (r_count),
            .i_word       (w_word),
            .i_next_data  (w_next_data),
            .i_next_match (w_next_match),
            .o_data       (w_data[i]),
            .o_match      (w_match[i])
        );
    end

    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_found     = r_found;
    assign o_position  = r_position;
    assign o_occupancy = r_occupancy;

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= FULL_COUNT)
    `ASSERT_NEXT(a_cmp_to_scan, i_clk, i_rst_n, r_state == S_CMP, r_state == S_SCAN)
    `ASSERT_NEXT(a_quick_result, i_clk, i_rst_n, w_accept && (i_action != ACT_SEARCH), o_strobe && !busy)
    `ASSERT_IMPL(a_found_done, i_clk, i_rst_n, o_strobe && o_found, o_status == STAT_DONE)
    `ASSERT_IMPL(a_scan_in_range, i_clk, i_rst_n, r_state == S_SCAN, r_pos <= r_count)

endmodule

`default_nettype wire
